/* rtl/rrcl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcl_pkg
// Shared widths, constants and the stage tag type for the rising-run chord
// length block.
// ----------------------------------------------------------------------------
package rrcl_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 8;

  // Fixed result widths
  localparam int COUNT_W = 16;
  localparam int CHORD_W = 25;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Control carried alongside the data through every stage and cell
  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } rrcl_tag_t;

endpackage

/* rtl/rising_run_chord_length.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rising_run_chord_length
// Rise count and chord length from the start of the current rising run.
// ----------------------------------------------------------------------------
// One result per input sample, in order. The block takes a sample every cycle
// while the result side keeps taking results; each result passes through the
// run tracking register, the square register, the sum register and one
// digit cell per root bit. A stall on the result side holds the whole chain,
// and in_ready drops with it. The chord is floor(sqrt(dx^2 + dy^2)) with
// FRACTION_BITS fractional bits; a sample that does not rise gives a zero
// count and sqrt(2), and the first sample of a curve gives zero for both.
module rising_run_chord_length import rrcl_pkg::*; #(
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_x_position,
  input  logic signed [SAMPLE_WIDTH-1:0] in_y_value,
  input  logic                           in_first_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic        [COUNT_W-1:0]      out_rise_count,
  output logic        [CHORD_W-1:0]      out_chord_length
);

  localparam int ROOT_W = SAMPLE_WIDTH + FRACTION_BITS + 1;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int SUM_W  = 2 * SAMPLE_WIDTH + 1;
  localparam int EXT_W  = (ROOT_W > CHORD_W) ? ROOT_W : CHORD_W;

  logic                    adv, accept;
  logic [SAMPLE_WIDTH-1:0] dx, dy;
  logic [SUM_W-1:0]        sum;
  rrcl_tag_t               tag_trk, tag_sum;

  logic [ROOT_W+1:0]       rem_c  [0:ROOT_W];
  logic [ROOT_W-1:0]       root_c [0:ROOT_W];
  logic [RAD_W-1:0]        rad_c  [0:ROOT_W];
  rrcl_tag_t               tag_c  [0:ROOT_W];
  logic [EXT_W-1:0]        root_ext;

  // Chain moves unless a finished result is waiting
  assign adv      = !tag_c[ROOT_W].valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  rrcl_track #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .accept  (accept),
    .x_i     (in_x_position),
    .y_i     (in_y_value),
    .first_i (in_first_sample),
    .dx_o    (dx),
    .dy_o    (dy),
    .tag_o   (tag_trk)
  );

  rrcl_square #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_square (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .dx_i  (dx),
    .dy_i  (dy),
    .tag_i (tag_trk),
    .sum_o (sum),
    .tag_o (tag_sum)
  );

  // Radicand scaled by 4^FRACTION_BITS enters the first cell
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;
  assign rad_c[0]  = RAD_W'(sum) << (2 * FRACTION_BITS);
  assign tag_c[0]  = tag_sum;

  // One cell per root bit
  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    rrcl_root_cell #(
      .ROOT_W(ROOT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .rem_i  (rem_c[i]),
      .root_i (root_c[i]),
      .rad_i  (rad_c[i]),
      .tag_i  (tag_c[i]),
      .rem_o  (rem_c[i+1]),
      .root_o (root_c[i+1]),
      .rad_o  (rad_c[i+1]),
      .tag_o  (tag_c[i+1])
    );
  end

  // Last cell is the output register
  assign root_ext         = EXT_W'(root_c[ROOT_W]);
  assign out_valid        = tag_c[ROOT_W].valid;
  assign out_rise_count   = tag_c[ROOT_W].count;
  assign out_chord_length = root_ext[CHORD_W-1:0];

endmodule

/* rtl/rrcl_track.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcl_track
// Run tracking front end: follows the strictly rising runs of y, forms the
// rise count and the coordinate differences from the run start point.
// ----------------------------------------------------------------------------
module rrcl_track import rrcl_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           accept,
  input  logic signed [SAMPLE_WIDTH-1:0] x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] y_i,
  input  logic                           first_i,
  output logic        [SAMPLE_WIDTH-1:0] dx_o,
  output logic        [SAMPLE_WIDTH-1:0] dy_o,
  output rrcl_tag_t                      tag_o
);

  localparam int DW = SAMPLE_WIDTH + 1;

  logic signed [SAMPLE_WIDTH-1:0] prev_x_r, prev_y_r, start_x_r, start_y_r;
  logic        [COUNT_W-1:0]      run_len_r, run_len_nxt;
  logic                           seen_r;

  logic        [SAMPLE_WIDTH-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  rrcl_tag_t                      tag_r, tag_nxt;

  logic                           fresh, rising;
  logic signed [DW-1:0]           diff_x, diff_y;
  logic        [DW-1:0]           mag_x, mag_y;
  logic        [COUNT_W-1:0]      run_len_inc, count_rise;

  // Differences to the run start, widened by one bit so they cannot wrap
  assign diff_x = DW'(x_i) - DW'(start_x_r);
  assign diff_y = DW'(y_i) - DW'(start_y_r);
  assign mag_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
  assign mag_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);

  assign fresh  = first_i || !seen_r;
  assign rising = y_i > prev_y_r;

  // Saturating run length and rise count
  assign run_len_inc = (run_len_r == COUNT_MAX) ? run_len_r : run_len_r + 1'b1;
  assign count_rise  = (run_len_inc == COUNT_MAX) ? COUNT_MAX : run_len_inc + 1'b1;

  // Per-sample outputs; a sample that does not rise is fed as a unit step on both axes
  always_comb begin
    tag_nxt.valid = accept;
    run_len_nxt   = run_len_r;
    if (fresh) begin
      dx_nxt        = '0;
      dy_nxt        = '0;
      tag_nxt.count = '0;
      run_len_nxt   = '0;
    end else if (rising) begin
      dx_nxt        = mag_x[SAMPLE_WIDTH-1:0];
      dy_nxt        = mag_y[SAMPLE_WIDTH-1:0];
      tag_nxt.count = count_rise;
      run_len_nxt   = run_len_inc;
    end else begin
      dx_nxt        = SAMPLE_WIDTH'(1);
      dy_nxt        = SAMPLE_WIDTH'(1);
      tag_nxt.count = '0;
      run_len_nxt   = '0;
    end
  end

  // Run state, updated on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
      run_len_r <= '0;
      seen_r    <= 1'b0;
    end else if (accept) begin
      prev_x_r  <= x_i;
      prev_y_r  <= y_i;
      run_len_r <= run_len_nxt;
      seen_r    <= 1'b1;
      if (fresh) begin
        start_x_r <= x_i;
        start_y_r <= y_i;
      end else if (!rising) begin
        start_x_r <= prev_x_r;
        start_y_r <= prev_y_r;
      end
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else if (adv) begin
      tag_r.valid <= tag_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r.count <= tag_nxt.count;
      dx_r        <= dx_nxt;
      dy_r        <= dy_nxt;
    end
  end

  assign dx_o  = dx_r;
  assign dy_o  = dy_r;
  assign tag_o = tag_r;

endmodule

/* rtl/rrcl_square.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcl_square
// Squares both differences, then sums them into the radicand, one register
// stage each.
// ----------------------------------------------------------------------------
module rrcl_square import rrcl_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [SAMPLE_WIDTH-1:0]   dx_i,
  input  logic [SAMPLE_WIDTH-1:0]   dy_i,
  input  rrcl_tag_t                 tag_i,
  output logic [2*SAMPLE_WIDTH:0]   sum_o,
  output rrcl_tag_t                 tag_o
);

  localparam int SQ_W  = 2 * SAMPLE_WIDTH;
  localparam int SUM_W = SQ_W + 1;

  logic [SQ_W-1:0]  sq_x_r, sq_y_r;
  logic [SUM_W-1:0] sum_r;
  rrcl_tag_t        tag_sq_r, tag_sum_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_sq_r.valid  <= 1'b0;
      tag_sum_r.valid <= 1'b0;
    end else if (adv) begin
      tag_sq_r.valid  <= tag_i.valid;
      tag_sum_r.valid <= tag_sq_r.valid;
    end
  end

  // Square stage, then sum stage
  always_ff @(posedge clk) begin
    if (adv) begin
      tag_sq_r.count  <= tag_i.count;
      sq_x_r          <= dx_i * dx_i;
      sq_y_r          <= dy_i * dy_i;
      tag_sum_r.count <= tag_sq_r.count;
      sum_r           <= SUM_W'(sq_x_r) + SUM_W'(sq_y_r);
    end
  end

  assign sum_o = sum_r;
  assign tag_o = tag_sum_r;

endmodule

/* rtl/rrcl_root_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcl_root_cell
// One digit cell of the square-root chain: brings down two radicand bits,
// tries the next root bit and hands its partial result to the next cell.
// ----------------------------------------------------------------------------
module rrcl_root_cell import rrcl_pkg::*; #(
  parameter int ROOT_W = SAMPLE_WIDTH_DEF + FRACTION_BITS_DEF + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [ROOT_W+1:0]     rem_i,
  input  logic [ROOT_W-1:0]     root_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  input  rrcl_tag_t             tag_i,
  output logic [ROOT_W+1:0]     rem_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [2*ROOT_W-1:0]   rad_o,
  output rrcl_tag_t             tag_o
);

  localparam int REM_W = ROOT_W + 2;
  localparam int RAD_W = 2 * ROOT_W;

  logic [REM_W-1:0] rem_r, rem_nxt, rem_sh, trial;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [RAD_W-1:0] rad_r;
  rrcl_tag_t        tag_r;
  logic             take;

  // Remainder stays below 2^ROOT_W before the shift, so the top bits drop
  assign rem_sh   = {rem_i[ROOT_W-1:0], rad_i[RAD_W-1 -: 2]};
  assign trial    = {root_i, 2'b01};
  assign take     = rem_sh >= trial;
  assign rem_nxt  = take ? rem_sh - trial : rem_sh;
  assign root_nxt = {root_i[ROOT_W-2:0], take};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else if (adv) begin
      tag_r.valid <= tag_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r.count <= tag_i.count;
      rem_r       <= rem_nxt;
      root_r      <= root_nxt;
      rad_r       <= {rad_i[RAD_W-3:0], 2'b00};
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;
  assign tag_o  = tag_r;

endmodule

/* rtl/rrcl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcl_checker
// Port-level assertions for the rising-run chord length block, bound to the
// top level.
// ----------------------------------------------------------------------------
module rrcl_checker import rrcl_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] out_rise_count,
  input logic [CHORD_W-1:0] out_chord_length
);

  localparam [CHORD_W-1:0]  TWO_STEPS = CHORD_W'(2) << FRACTION_BITS;

  // Held result keeps its value until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_rise_count) && $stable(out_chord_length))
    else $error("result changed while stalled");

  // Input side only waits on a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");

  // A rising sample has at least one step behind it, so never a count of one
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rise_count != COUNT_W'(1))
    else $error("rise count of one");

  // Without a rise the chord is either zero or the unit diagonal, below two
  a_chord: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rise_count == '0 |-> out_chord_length < TWO_STEPS)
    else $error("chord too long for a sample that does not rise");

endmodule

bind rising_run_chord_length rrcl_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_rrcl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_rise_count   (out_rise_count),
  .out_chord_length (out_chord_length)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rising-run chord length block.
// ----------------------------------------------------------------------------
// A queue of curve samples feeds a clocked driver. The driver predicts rise
// count and chord length for every accepted sample. A clocked monitor checks
// each result transfer against the oldest prediction. Stimulus is a directed
// set, then random curves and noise, about 400 samples in all. Both sides
// idle at random, and the receiver holds off once for a long stretch so that
// the pipeline backs up.
// ----------------------------------------------------------------------------
module tb import rrcl_pkg::*;;

  localparam int SW           = SAMPLE_WIDTH_DEF;
  localparam int FB           = FRACTION_BITS_DEF;
  localparam int LATENCY      = SW + FB + 4;
  localparam int DRAIN_CYCLES = 2 * LATENCY + 8;
  localparam int RANDOM_ITEMS = 380;
  localparam int MAX_GAP      = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 60;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic                 first;
  } sample_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [CHORD_W-1:0] chord;
  } chord_result_t;

  // Clock, reset and block ports
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [SW-1:0] in_x_position = '0;
  logic signed [SW-1:0] in_y_value = '0;
  logic                 in_first_sample = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COUNT_W-1:0]   out_rise_count;
  logic [CHORD_W-1:0]   out_chord_length;

  // Stimulus and expectations
  sample_t       pending_samples[$];
  chord_result_t expected_results[$];
  int            mismatches = 0;
  int            accepted_cnt = 0;
  longint        cycle_cnt = 0;
  longint        cycle_limit = 64'd1 << 40;

  // Predictor state
  logic signed [SW-1:0] last_x = '0;
  logic signed [SW-1:0] last_y = '0;
  logic signed [SW-1:0] start_x = '0;
  logic signed [SW-1:0] start_y = '0;
  int                   run_len = 0;
  bit                   have_sample = 1'b0;

  // Idling state
  int gap_left = 0;
  bit in_steady = 1'b0;
  int stall_left = 0;
  bit out_steady = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  rising_run_chord_length i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_x_position    (in_x_position),
    .in_y_value       (in_y_value),
    .in_first_sample  (in_first_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_rise_count   (out_rise_count),
    .out_chord_length (out_chord_length)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // floor(sqrt(sum_sq * 4^FB)), digit by digit
  function automatic logic [CHORD_W-1:0] scaled_sqrt(longint unsigned sum_sq);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitval;
    rem    = sum_sq << (2 * FB);
    root   = 0;
    bitval = 64'd1 << 62;
    while (bitval > rem) bitval = bitval >> 2;
    while (bitval != 0) begin
      if (rem >= root + bitval) begin
        rem  = rem - (root + bitval);
        root = (root >> 1) + bitval;
      end else begin
        root = root >> 1;
      end
      bitval = bitval >> 2;
    end
    return root[CHORD_W-1:0];
  endfunction

  // Run tracking for one accepted sample; queues the expected result
  task automatic predict_chord(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
                               logic first);
    chord_result_t   res;
    longint          dx;
    longint          dy;
    longint unsigned sum_sq;
    res = '0;
    if (first || !have_sample) begin
      start_x     = x;
      start_y     = y;
      run_len     = 0;
      have_sample = 1'b1;
    end else if (y > last_y) begin
      dx = longint'(x) - longint'(start_x);
      dy = longint'(y) - longint'(start_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sum_sq = longint'(dx * dx + dy * dy);
      if (run_len < int'(COUNT_MAX)) run_len++;
      res.count = (run_len + 1 > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(run_len + 1);
      res.chord = scaled_sqrt(sum_sq);
    end else begin
      run_len   = 0;
      start_x   = last_x;
      start_y   = last_y;
      res.chord = scaled_sqrt(64'd2);
    end
    last_x = x;
    last_y = y;
    expected_results.push_back(res);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] chord check: %s got %0d wanted %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Mostly short gaps, a few long ones; none while steady
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, MAX_GAP);
  endfunction

  function automatic void queue_sample(int x, int y, bit first);
    sample_t s;
    s.x     = x[SW-1:0];
    s.y     = y[SW-1:0];
    s.first = first;
    pending_samples.push_back(s);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Input driver: predicts on each transfer, then offers the next sample
  always @(posedge clk) begin : sample_driver
    sample_t nxt;
    bit      free;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      free = !in_valid;
      if (in_valid && in_ready) begin
        predict_chord(in_x_position, in_y_value, in_first_sample);
        accepted_cnt <= accepted_cnt + 1;
        free = 1'b1;
      end
      if (free) begin
        if (gap_left > 0 || pending_samples.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          nxt = pending_samples.pop_front();
          in_valid        <= 1'b1;
          in_x_position   <= nxt.x;
          in_y_value      <= nxt.y;
          in_first_sample <= nxt.first;
          gap_left        <= pick_gap(in_steady);
          if ($urandom_range(0, 39) == 0) in_steady <= !in_steady;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin : result_monitor
    chord_result_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer, count", longint'(out_rise_count),
                          longint'(0));
        end else begin
          want = expected_results.pop_front();
          if (out_rise_count !== want.count)
            report_mismatch("rise_count", longint'(out_rise_count),
                            longint'(want.count));
          if (out_chord_length !== want.chord)
            report_mismatch("chord_length", longint'(out_chord_length),
                            longint'(want.chord));
        end
      end
      if (stall_left > 0) stall_left <= stall_left - 1;
      else if (!out_steady && $urandom_range(0, 2) == 0) stall_left <= pick_gap(1'b0);
      out_ready <= (stall_left == 0) && (hold_left == 0);
      if ($urandom_range(0, 199) == 0) out_steady <= !out_steady;
    end
  end

  // One long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin : long_hold_off
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= cycle_limit) begin
      $display("rising_run_chord_length: mismatch");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int x;
    int y;
    int ny;
    int len;
    int r;
    int step;
    int rand_cnt;

    // Directed: no sample yet with the flag low, then basic rise/flat/fall
    queue_sample(0, 0, 1'b0);
    queue_sample(1, 5, 1'b0);
    queue_sample(2, 5, 1'b0);
    queue_sample(3, 4, 1'b0);
    // Extremes: widest chord, then a flat step at the top
    queue_sample(-32768, -32768, 1'b1);
    queue_sample(32767, 32767, 1'b0);
    queue_sample(-32768, 32767, 1'b0);
    // Growing run from the bottom of the range
    queue_sample(0, -32768, 1'b1);
    queue_sample(5, -32767, 1'b0);
    queue_sample(10, -32000, 1'b0);
    queue_sample(20, 0, 1'b0);
    queue_sample(-32768, 32767, 1'b0);
    // New curve flagged on a value below the last one, then a rise
    queue_sample(7, 100, 1'b1);
    queue_sample(7, 200, 1'b0);
    // Dip then rise: run starts at the sample before the lowest one
    queue_sample(8, 150, 1'b0);
    queue_sample(9, 160, 1'b0);
    queue_sample(-9, 170, 1'b0);
    // Bit patterns
    queue_sample(16'h5555, -21846, 1'b1);
    queue_sample(-21846, 16'h5555, 1'b0);
    queue_sample(16'h5555, 16'h5555, 1'b0);
    queue_sample(-1, -1, 1'b0);
    queue_sample(0, 0, 1'b0);

    // Random curves, mostly rising, with some noise
    rand_cnt = 0;
    while (rand_cnt < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_sample(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
        rand_cnt++;
      end else begin
        len = $urandom_range(2, 40);
        x   = rand_coord();
        y   = rand_coord();
        queue_sample(x, y, 1'b1);
        rand_cnt++;
        for (int k = 1; k < len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 70)      step = $urandom_range(1, 50);
          else if (r < 80) step = $urandom_range(1, 20000);
          else if (r < 90) step = 0;
          else             step = -int'($urandom_range(1, 300));
          ny = y + step;
          if (ny > 32767) ny = 32767;
          if (ny < -32768) ny = -32768;
          y = ny;
          if ($urandom_range(0, 1) == 0) x = x + int'($urandom_range(0, 20)) - 10;
          else x = rand_coord();
          queue_sample(x, y, 1'b0);
          rand_cnt++;
        end
      end
    end

    cycle_limit = longint'(pending_samples.size()) * (2 * MAX_GAP + 4) * 3
                  + HOLD_CYCLES + 10000;

    // Reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_samples.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("rising_run_chord_length: match");
    end else begin
      $display("rising_run_chord_length: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rrcl_pkg.sv
rtl/rrcl_track.sv
rtl/rrcl_square.sv
rtl/rrcl_root_cell.sv
rtl/rising_run_chord_length.sv
rtl/rrcl_checker.sv
verif/tb.sv
